/* rtl/pfc_pkg.sv */
// shared types, constants and matcher step functions for the frame classifier
// no dependencies

package pfc_pkg;

   localparam int MAX_FRAME_BYTES_DEFAULT = 16383;
   localparam int QUEUE_DEPTH = 2;

   localparam int PROTO_OFFSET = 23;
   localparam int SRC_FIRST = 26;
   localparam int SRC_END = 30;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   localparam logic [2:0] ROUTE_DROP = 3'd0;
   localparam logic [2:0] ROUTE_HTTP = 3'd1;
   localparam logic [2:0] ROUTE_UDP = 3'd2;
   localparam logic [2:0] ROUTE_ICMP = 3'd3;
   localparam logic [2:0] ROUTE_FTP = 3'd4;
   localparam logic [2:0] ROUTE_TCP = 3'd5;

   localparam logic [0:7][7:0] HTTP_PAT = {8'd72, 8'd84, 8'd84, 8'd80,
                                           8'd47, 8'd49, 8'd46, 8'd49};
   localparam logic [0:2][7:0] FTP_LO_PAT = {8'd102, 8'd116, 8'd112};
   localparam logic [0:2][7:0] FTP_UP_PAT = {8'd70, 8'd84, 8'd80};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] route;
      logic       controller_called;
   } rsp_payload_type;

   // per-frame summary handed from the front to the back
   typedef struct packed {
      logic [7:0]  protocol;
      logic [31:0] source;
      logic        http_seen;
      logic        ftp_seen;
   } frame_sum_type;

   typedef struct packed {
      logic [2:0] prog;
      logic       hit;
   } http_step_type;

   typedef struct packed {
      logic [1:0] prog;
      logic       hit;
   } ftp_step_type;

   // first pattern byte never recurs, so a mismatch restarts only on it
   function automatic http_step_type http_advance(logic [2:0] prog, logic [7:0] b);
      http_step_type r;
      r.hit = 1'b0;
      if (b == HTTP_PAT[prog]) begin
         if (prog == 3'd7) begin
            r.prog = 3'd0;
            r.hit = 1'b1;
         end else begin
            r.prog = prog + 3'd1;
         end
      end else begin
         r.prog = (b == HTTP_PAT[0]) ? 3'd1 : 3'd0;
      end
      return r;
   endfunction

   function automatic ftp_step_type ftp_advance(logic [1:0] prog, logic [7:0] b,
                                                logic [0:2][7:0] pat);
      ftp_step_type r;
      logic [1:0]   p;
      p = (prog == 2'd3) ? 2'd0 : prog;
      r.hit = 1'b0;
      if (b == pat[p]) begin
         if (p == 2'd2) begin
            r.prog = 2'd0;
            r.hit = 1'b1;
         end else begin
            r.prog = p + 2'd1;
         end
      end else begin
         r.prog = (b == pat[0]) ? 2'd1 : 2'd0;
      end
      return r;
   endfunction

endpackage

/* rtl/pfc_front.sv */
// front end: per-byte header capture and signature matchers
// depends on pfc_pkg

module pfc_front #(
   parameter int MAX_FRAME_BYTES = pfc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pfc_pkg::req_payload_type req_data,
   input  logic                     queue_full,
   output logic                     push,
   output pfc_pkg::frame_sum_type   push_data
);
   import pfc_pkg::*;

   localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);

   logic [OFF_W-1:0] offset_ff, offset_in;
   logic [7:0]       proto_ff, proto_in;
   logic [31:0]      src_ff, src_in;
   logic [2:0]       http_prog_ff, http_prog_in;
   logic [1:0]       ftpl_prog_ff, ftpl_prog_in;
   logic [1:0]       ftpu_prog_ff, ftpu_prog_in;
   logic             http_seen_ff, http_seen_in;
   logic             ftp_seen_ff, ftp_seen_in;

   logic            accept;
   logic [7:0]      b;
   http_step_type   http_s;
   ftp_step_type    ftpl_s, ftpu_s;
   logic [7:0]      proto_nx;
   logic [31:0]     src_nx;
   logic            http_seen_nx, ftp_seen_nx;

   assign req_stall = queue_full;
   assign accept = req_valid && !req_stall;
   assign b = req_data.data_byte;

   always_comb begin
      http_s = http_advance(http_prog_ff, b);
      ftpl_s = ftp_advance(ftpl_prog_ff, b, FTP_LO_PAT);
      ftpu_s = ftp_advance(ftpu_prog_ff, b, FTP_UP_PAT);
      proto_nx = (offset_ff == OFF_W'(PROTO_OFFSET)) ? b : proto_ff;
      src_nx = (offset_ff >= OFF_W'(SRC_FIRST) && offset_ff < OFF_W'(SRC_END)) ?
               {src_ff[23:0], b} : src_ff;
      http_seen_nx = http_seen_ff || http_s.hit;
      ftp_seen_nx = ftp_seen_ff || ftpl_s.hit || ftpu_s.hit;
   end

   assign push = accept && req_data.last_byte;
   assign push_data = '{protocol: proto_nx, source: src_nx,
                        http_seen: http_seen_nx, ftp_seen: ftp_seen_nx};

   always_comb begin
      offset_in = offset_ff;
      proto_in = proto_ff;
      src_in = src_ff;
      http_prog_in = http_prog_ff;
      ftpl_prog_in = ftpl_prog_ff;
      ftpu_prog_in = ftpu_prog_ff;
      http_seen_in = http_seen_ff;
      ftp_seen_in = ftp_seen_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            // frame done, start the next one at offset zero
            offset_in = '0;
            proto_in = '0;
            src_in = '0;
            http_prog_in = '0;
            ftpl_prog_in = '0;
            ftpu_prog_in = '0;
            http_seen_in = 1'b0;
            ftp_seen_in = 1'b0;
         end else begin
            if (offset_ff < OFF_W'(MAX_FRAME_BYTES)) begin
               offset_in = offset_ff + OFF_W'(1);
            end
            proto_in = proto_nx;
            src_in = src_nx;
            http_prog_in = http_s.prog;
            ftpl_prog_in = ftpl_s.prog;
            ftpu_prog_in = ftpu_s.prog;
            http_seen_in = http_seen_nx;
            ftp_seen_in = ftp_seen_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         proto_ff <= '0;
         src_ff <= '0;
         http_prog_ff <= '0;
         ftpl_prog_ff <= '0;
         ftpu_prog_ff <= '0;
         http_seen_ff <= 1'b0;
         ftp_seen_ff <= 1'b0;
      end else begin
         offset_ff <= offset_in;
         proto_ff <= proto_in;
         src_ff <= src_in;
         http_prog_ff <= http_prog_in;
         ftpl_prog_ff <= ftpl_prog_in;
         ftpu_prog_ff <= ftpu_prog_in;
         http_seen_ff <= http_seen_in;
         ftp_seen_ff <= ftp_seen_in;
      end
   end

   a_offset_sat: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= OFF_W'(MAX_FRAME_BYTES))
      else $error("byte offset past saturation point");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      push |=> offset_ff == '0 && !http_seen_ff && !ftp_seen_ff)
      else $error("frame state not cleared after last byte");

   a_push_on_last: assert property (@(posedge clock) disable iff (reset)
      push |-> req_data.last_byte && !queue_full)
      else $error("summary pushed without a last byte transfer");

endmodule

/* rtl/pfc_queue.sv */
// short queue of frame summaries between front and back
// depends on pfc_pkg

module pfc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pfc_pkg::frame_sum_type push_data,
   output logic                   full,
   output logic                   head_valid,
   input  logic                   pop,
   output pfc_pkg::frame_sum_type head_data
);
   import pfc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_sum_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("summary pushed into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("summary popped from empty queue");

endmodule

/* rtl/pfc_back.sv */
// back end: route choice, flow cache and result register
// depends on pfc_pkg

module pfc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  pfc_pkg::frame_sum_type   head_data,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output pfc_pkg::rsp_payload_type rsp_data
);
   import pfc_pkg::*;

   logic [31:0]     cached_src_ff, cached_src_in;
   logic            cache_valid_ff, cache_valid_in;
   logic [2:0]      prev_rule_ff, prev_rule_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [2:0] cand, rule;
   logic       hit;

   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      cand = ROUTE_DROP;
      rule = ROUTE_ICMP;
      case (head_data.protocol)
         PROTO_TCP: begin
            cand = head_data.http_seen ? ROUTE_HTTP :
                   ((head_data.ftp_seen || prev_rule_ff == ROUTE_FTP) ? ROUTE_FTP : ROUTE_TCP);
            rule = head_data.http_seen ? ROUTE_HTTP :
                   (head_data.ftp_seen ? ROUTE_FTP : ROUTE_TCP);
         end
         PROTO_UDP: begin
            cand = head_data.http_seen ? ROUTE_HTTP : ROUTE_UDP;
            rule = head_data.http_seen ? ROUTE_HTTP :
                   (head_data.ftp_seen ? ROUTE_FTP : ROUTE_UDP);
         end
         PROTO_ICMP: begin
            cand = ROUTE_ICMP;
         end
         default: begin
            cand = ROUTE_DROP;
         end
      endcase
      hit = cache_valid_ff && head_data.source == cached_src_ff && cand == prev_rule_ff;
   end

   always_comb begin
      cached_src_in = cached_src_ff;
      cache_valid_in = cache_valid_ff;
      prev_rule_in = prev_rule_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         rsp_valid_in = 1'b1;
         if (cand == ROUTE_DROP) begin
            rsp_data_in = '{route: ROUTE_DROP, controller_called: 1'b0};
         end else if (hit) begin
            rsp_data_in = '{route: cand, controller_called: 1'b0};
         end else begin
            // miss: controller sets the rule and refills the cache
            rsp_data_in = '{route: rule, controller_called: 1'b1};
            cached_src_in = head_data.source;
            cache_valid_in = 1'b1;
            prev_rule_in = rule;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cached_src_ff <= '0;
         cache_valid_ff <= 1'b0;
         prev_rule_ff <= ROUTE_DROP;
         rsp_valid_ff <= 1'b0;
      end else begin
         cached_src_ff <= cached_src_in;
         cache_valid_ff <= cache_valid_in;
         prev_rule_ff <= prev_rule_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   a_called_not_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.controller_called |-> rsp_data_ff.route != ROUTE_DROP)
      else $error("controller call with drop route");

   a_cache_filled: assert property (@(posedge clock) disable iff (reset)
      pop && cand != ROUTE_DROP |=> cache_valid_ff)
      else $error("cache not valid after routed frame");

   a_rule_matches: assert property (@(posedge clock) disable iff (reset)
      pop && cand != ROUTE_DROP && !hit |=> prev_rule_ff == rsp_data_ff.route)
      else $error("stored rule differs from emitted route");

endmodule

/* rtl/packet_flow_classifier_unit.sv */
// top level of the frame classifier: front end, summary queue, back end
// depends on pfc_pkg, pfc_front, pfc_queue, pfc_back

// Takes one frame byte per cycle on the req channel while not stalled, last
// byte marked, and returns one route per frame on the rsp channel. The front
// end stalls only while its two-entry summary queue is full, which happens
// when rsp stays stalled. A frame's summary is registered in the queue and
// its route then in the result register. The back end retires one frame per
// cycle unless a held result is stalled on rsp. The one-entry flow cache and
// the stored rule live in the back end and are updated in frame order.

module packet_flow_classifier_unit #(
   parameter int MAX_FRAME_BYTES = pfc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pfc_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output pfc_pkg::rsp_payload_type rsp_data
);
   import pfc_pkg::*;

   logic          queue_full, push, head_valid, pop;
   frame_sum_type push_data, head_data;

   pfc_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   pfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .pop        (pop),
      .head_data  (head_data)
   );

   pfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
